### hdl/mcr_pkg.sv
// Shared types and constants for the half-pel motion compensation reconstruct block.
// No dependencies; used by every module in hdl/.
`default_nettype none

package mcr_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned QuantW  = SampleW - 4;  // chroma sample in units of 16

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_FWD  = 2'd1,
    OP_BWD  = 2'd2,
    OP_AVG  = 2'd3
  } mcr_op_e;

  typedef logic signed [SampleW-1:0] sample_t;

  // 2x2 reference neighborhood
  typedef struct packed {
    sample_t tl;
    sample_t tr;
    sample_t bl;
    sample_t br;
  } mcr_nbhd_t;

  typedef struct packed {
    logic en;      // half-pel enable register
    logic x_half;
    logic y_half;
  } mcr_phase_t;

  localparam logic signed [QuantW-1:0] ChromaQMin = -QuantW'(128);
  localparam logic signed [QuantW-1:0] ChromaQMax = QuantW'(127);
  localparam sample_t SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleW-1){1'b0}}};

endpackage

`default_nettype wire

### hdl/mcr_predict.sv
// Half-pel interpolation of one 2x2 reference neighborhood: copy, 2-tap or 4-tap floor average.
// Depends on mcr_pkg.
`default_nettype none

module mcr_predict import mcr_pkg::*; (
  input  mcr_nbhd_t  nbhd_i,
  input  mcr_phase_t phase_i,
  output sample_t    pred_o
);

  logic signed [SampleW+1:0] sum4;
  logic signed [SampleW:0]   sum_x;
  logic signed [SampleW:0]   sum_y;

  always_comb begin
    sum4  = (SampleW+2)'(nbhd_i.tl) + (SampleW+2)'(nbhd_i.tr)
          + (SampleW+2)'(nbhd_i.bl) + (SampleW+2)'(nbhd_i.br);
    sum_x = (SampleW+1)'(nbhd_i.tl) + (SampleW+1)'(nbhd_i.tr);
    sum_y = (SampleW+1)'(nbhd_i.tl) + (SampleW+1)'(nbhd_i.bl);
    // arithmetic shift rounds toward minus infinity
    if (!phase_i.en || (!phase_i.x_half && !phase_i.y_half)) begin
      pred_o = nbhd_i.tl;
    end else if (phase_i.x_half && phase_i.y_half) begin
      pred_o = sum4[SampleW+1:2];
    end else if (phase_i.x_half) begin
      pred_o = sum_x[SampleW:1];
    end else begin
      pred_o = sum_y[SampleW:1];
    end
  end

endmodule

`default_nettype wire

### hdl/half_pel_motion_comp_reconstruct_top.sv
// Top level of the half-pel motion compensation reconstruct pipeline.
// Depends on mcr_pkg and mcr_predict.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid_i/in_stall_o| operation, phases, is_chroma, residual, 2x2 x2
//  out     | out_valid_o/out_stall_i | pixel_out_o, saturated_o
//  cfg     | cfg_we_i             | cfg_wdata_i (half_pel_enable)
//
// Three register stages: interpolation, prediction select/average, add/saturate/clamp.
// One pixel per clock while out_stall_i is low; out_valid_o rises once an accepted input
// has passed the interpolation, select/average and add/saturate/clamp registers.
// Each stage advances when the next one is empty or advancing, so bubbles collapse.
// A stall holds the output register; the input stalls only with all stages full.
// Reset clears the stage valid bits and sets half_pel_enable to 1.
`default_nettype none

module half_pel_motion_comp_reconstruct_top import mcr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [PhaseW-1:0]   half_pel_phases_i,
  input  logic                is_chroma_i,
  input  logic signed [15:0]  residual_i,
  input  logic signed [15:0]  past_top_left_i,
  input  logic signed [15:0]  past_top_right_i,
  input  logic signed [15:0]  past_bottom_left_i,
  input  logic signed [15:0]  past_bottom_right_i,
  input  logic signed [15:0]  future_top_left_i,
  input  logic signed [15:0]  future_top_right_i,
  input  logic signed [15:0]  future_bottom_left_i,
  input  logic signed [15:0]  future_bottom_right_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  pixel_out_o,
  output logic                saturated_o
);

  logic hp_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      hp_en_q <= cfg_wdata_i;
    end
  end

  // stage flow control
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3 = !v3_q || !out_stall_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // stage 1: interpolation
  mcr_nbhd_t  past_nbhd, fut_nbhd;
  mcr_phase_t fwd_ph, bwd_ph;
  sample_t    fwd_pred, bwd_pred;

  assign past_nbhd = '{tl: past_top_left_i, tr: past_top_right_i,
                       bl: past_bottom_left_i, br: past_bottom_right_i};
  assign fut_nbhd  = '{tl: future_top_left_i, tr: future_top_right_i,
                       bl: future_bottom_left_i, br: future_bottom_right_i};
  assign fwd_ph = '{en: hp_en_q, x_half: half_pel_phases_i[0], y_half: half_pel_phases_i[1]};
  assign bwd_ph = '{en: hp_en_q, x_half: half_pel_phases_i[2], y_half: half_pel_phases_i[3]};

  mcr_predict u_pred_fwd (.nbhd_i(past_nbhd), .phase_i(fwd_ph), .pred_o(fwd_pred));
  mcr_predict u_pred_bwd (.nbhd_i(fut_nbhd),  .phase_i(bwd_ph), .pred_o(bwd_pred));

  sample_t fwd1_q, bwd1_q, res1_q;
  mcr_op_e op1_q;
  logic    chroma1_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      fwd1_q    <= fwd_pred;
      bwd1_q    <= bwd_pred;
      res1_q    <= residual_i;
      op1_q     <= mcr_op_e'(operation_i);
      chroma1_q <= is_chroma_i;
    end
  end

  // stage 2: prediction select / bidirectional average
  logic signed [SampleW:0] bi_sum;
  sample_t pred_d, pred2_q, res2_q;
  logic    chroma2_q;

  always_comb begin
    bi_sum = (SampleW+1)'(fwd1_q) + (SampleW+1)'(bwd1_q);
    case (op1_q)
      OP_FWD:  pred_d = fwd1_q;
      OP_BWD:  pred_d = bwd1_q;
      OP_AVG:  pred_d = bi_sum[SampleW:1];
      default: pred_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      pred2_q   <= pred_d;
      res2_q    <= res1_q;
      chroma2_q <= chroma1_q;
    end
  end

  // stage 3: add, saturate, chroma clamp
  logic signed [SampleW:0]  full_sum;
  sample_t                  sat_sum, pix_d;
  logic                     sat_d;
  logic signed [QuantW-1:0] q;
  logic signed [QuantW-1:0] q_clamped;

  always_comb begin
    full_sum = (SampleW+1)'(res2_q) + (SampleW+1)'(pred2_q);
    sat_d    = full_sum[SampleW] != full_sum[SampleW-1];
    if (!sat_d) begin
      sat_sum = full_sum[SampleW-1:0];
    end else if (full_sum[SampleW]) begin
      sat_sum = SampleMin;
    end else begin
      sat_sum = SampleMax;
    end
    q = sat_sum[SampleW-1:4];
    if (q < ChromaQMin) begin
      q_clamped = ChromaQMin;
    end else if (q > ChromaQMax) begin
      q_clamped = ChromaQMax;
    end else begin
      q_clamped = q;
    end
    pix_d = chroma2_q ? {q_clamped, 4'b0000} : sat_sum;
  end

  sample_t pix3_q;
  logic    sat3_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      pix3_q <= pix_d;
      sat3_q <= sat_d;
    end
  end

  assign out_valid_o = v3_q;
  assign pixel_out_o = pix3_q;
  assign saturated_o = sat3_q;

endmodule

`default_nettype wire

### hdl/mcr_checker.sv
// Port-level assertions for half_pel_motion_comp_reconstruct_top, attached by bind.
// Depends on mcr_pkg.
`default_nettype none

module mcr_checker import mcr_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input logic signed [15:0] pixel_out_o,
  input logic          saturated_o
);

  // no output transfer offered while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // input backs up only when the whole pipe is held by the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

  // saturation leaves a rail value, or its chroma-clamped image
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (pixel_out_o == SampleMax || pixel_out_o == SampleMin ||
       pixel_out_o == 16'sd2032 || pixel_out_o == -16'sd2048))
    else $error("saturated flag with non-rail pixel");

  // stalled transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(pixel_out_o) && $stable(saturated_o)))
    else $error("stalled output changed");

endmodule

bind half_pel_motion_comp_reconstruct_top mcr_checker u_mcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pixel_out_o (pixel_out_o),
  .saturated_o (saturated_o)
);

`default_nettype wire

### dv/tb_half_pel_motion_comp_reconstruct_top.sv
// Self-checking testbench for half_pel_motion_comp_reconstruct_top.
// Depends on mcr_pkg and the block's RTL; a local predictor computes every expected pixel.
`timescale 1ns / 100ps

module tb_half_pel_motion_comp_reconstruct_top import mcr_pkg::*;;

  localparam int unsigned PipeLatency = 3;
  localparam int unsigned CycleLimit  = 1000000;

  typedef struct {
    mcr_op_e         op;
    logic [3:0]      phases;
    logic            chroma;
    sample_t         residual;
    mcr_nbhd_t       past;
    mcr_nbhd_t       future;
  } pixel_req_t;

  typedef struct {
    sample_t pixel;
    logic    sat;
  } recon_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i              = 1'b0;
  logic                cfg_wdata_i           = 1'b0;
  logic                in_valid_i            = 1'b0;
  logic                in_stall_o;
  logic [1:0]          operation_i           = '0;
  logic [PhaseW-1:0]   half_pel_phases_i     = '0;
  logic                is_chroma_i           = 1'b0;
  logic signed [15:0]  residual_i            = '0;
  logic signed [15:0]  past_top_left_i       = '0;
  logic signed [15:0]  past_top_right_i      = '0;
  logic signed [15:0]  past_bottom_left_i    = '0;
  logic signed [15:0]  past_bottom_right_i   = '0;
  logic signed [15:0]  future_top_left_i     = '0;
  logic signed [15:0]  future_top_right_i    = '0;
  logic signed [15:0]  future_bottom_left_i  = '0;
  logic signed [15:0]  future_bottom_right_i = '0;
  logic                out_valid_o;
  logic                out_stall_i           = 1'b0;
  logic signed [15:0]  pixel_out_o;
  logic                saturated_o;

  recon_t      expected_pixels[$];
  logic        model_half_pel = 1'b1;  // reset value of the register
  bit          idle_on        = 1'b1;
  int unsigned stall_left     = 0;
  int unsigned sent_count     = 0;
  int unsigned checked_count  = 0;
  int unsigned fail_count     = 0;
  int unsigned cfg_writes     = 0;
  int unsigned cycle_count    = 0;

  half_pel_motion_comp_reconstruct_top uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL half_pel_motion_comp_reconstruct_top");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int interp_ref(mcr_nbhd_t n, logic xh, logic yh, logic en);
    int tl, tr, bl, br;
    tl = n.tl;
    tr = n.tr;
    bl = n.bl;
    br = n.br;
    if (!en || (!xh && !yh)) return tl;
    if (xh && yh) return (tl + tr + bl + br) >>> 2;
    if (xh) return (tl + tr) >>> 1;
    return (tl + bl) >>> 1;
  endfunction

  function automatic recon_t reconstruct_pixel(pixel_req_t p, logic en);
    int fwd, bwd, pred, acc, q;
    recon_t r;
    fwd = interp_ref(p.past, p.phases[0], p.phases[1], en);
    bwd = interp_ref(p.future, p.phases[2], p.phases[3], en);
    case (p.op)
      OP_FWD:  pred = fwd;
      OP_BWD:  pred = bwd;
      OP_AVG:  pred = (fwd + bwd) >>> 1;
      default: pred = 0;
    endcase
    acc = int'(p.residual) + pred;
    r.sat = 1'b0;
    if (acc > int'(SampleMax)) begin
      acc = int'(SampleMax);
      r.sat = 1'b1;
    end else if (acc < int'(SampleMin)) begin
      acc = int'(SampleMin);
      r.sat = 1'b1;
    end
    // chroma clamp works on the saturated sum, in units of 16
    if (p.chroma) begin
      q = acc >>> 4;
      if (q < int'(ChromaQMin)) q = int'(ChromaQMin);
      if (q > int'(ChromaQMax)) q = int'(ChromaQMax);
      acc = q * 16;
    end
    r.pixel = sample_t'(acc);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return SampleMax;
      1:       return SampleMin;
      2:       return sample_t'(int'($urandom_range(0, 31)) - 16);
      3:       return sample_t'(32767 - int'($urandom_range(0, 63)));
      4:       return sample_t'(-32768 + int'($urandom_range(0, 63)));
      5:       return sample_t'(($urandom_range(0, 1) ? 2048 : -2048)
                                + int'($urandom_range(0, 31)) - 16);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic mcr_nbhd_t nb(int tl, int tr, int bl, int br);
    mcr_nbhd_t n;
    n.tl = sample_t'(tl);
    n.tr = sample_t'(tr);
    n.bl = sample_t'(bl);
    n.br = sample_t'(br);
    return n;
  endfunction

  function automatic pixel_req_t make_req(mcr_op_e op, logic [3:0] ph, logic chroma,
                                          int res, mcr_nbhd_t past, mcr_nbhd_t fut);
    pixel_req_t p;
    p.op       = op;
    p.phases   = ph;
    p.chroma   = chroma;
    p.residual = sample_t'(res);
    p.past     = past;
    p.future   = fut;
    return p;
  endfunction

  function automatic pixel_req_t random_pixel();
    return make_req(mcr_op_e'($urandom_range(0, 3)), 4'($urandom()), 1'($urandom()),
                    int'(rand_sample()),
                    nb(rand_sample(), rand_sample(), rand_sample(), rand_sample()),
                    nb(rand_sample(), rand_sample(), rand_sample(), rand_sample()));
  endfunction

  // call at a rising edge; returns at the edge of the transfer or after the gap
  task automatic send_pixel(pixel_req_t p);
    int unsigned gap;
    in_valid_i            <= 1'b1;
    operation_i           <= p.op;
    half_pel_phases_i     <= p.phases;
    is_chroma_i           <= p.chroma;
    residual_i            <= p.residual;
    past_top_left_i       <= p.past.tl;
    past_top_right_i      <= p.past.tr;
    past_bottom_left_i    <= p.past.bl;
    past_bottom_right_i   <= p.past.br;
    future_top_left_i     <= p.future.tl;
    future_top_right_i    <= p.future.tr;
    future_bottom_left_i  <= p.future.bl;
    future_bottom_right_i <= p.future.br;
    do @(posedge clk_i); while (in_stall_o);
    expected_pixels.push_back(reconstruct_pixel(p, model_half_pel));
    sent_count++;
    gap = idle_on ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_idle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  task automatic set_half_pel(logic v);
    wait_for_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    model_half_pel = v;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------- output side

  always @(posedge clk_i) begin
    if (!idle_on) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = idle_len();
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin : check_output
    recon_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected output transfer: pixel_out %0d saturated %0b",
               pixel_out_o, saturated_o);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        checked_count++;
        if (pixel_out_o !== want.pixel) begin
          $error("pixel_out: expected %0d, got %0d", want.pixel, pixel_out_o);
          fail_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // runs with the reset value of half_pel_enable
  task automatic test_directed_corners();
    mcr_nbhd_t z;
    z = nb(0, 0, 0, 0);
    // no prediction: residual passes, chroma still clamped, phases ignored
    send_pixel(make_req(OP_NONE, 4'hF, 1'b0, 32767, nb(-1, -1, -1, -1), z));
    send_pixel(make_req(OP_NONE, 4'h0, 1'b1, -32768, z, nb(32767, 1, 2, 3)));
    send_pixel(make_req(OP_NONE, 4'h5, 1'b1, -17, z, z));
    send_pixel(make_req(OP_NONE, 4'h0, 1'b1, 2047, z, z));
    send_pixel(make_req(OP_NONE, 4'hA, 1'b1, 2048, z, z));
    // forward: copy, x half, y half, both; odd negative sums round down
    send_pixel(make_req(OP_FWD, 4'h0, 1'b0, 0, nb(-5, 32767, 32767, 32767), z));
    send_pixel(make_req(OP_FWD, 4'h1, 1'b0, 0, nb(-3, 0, 32767, 32767), z));
    send_pixel(make_req(OP_FWD, 4'h2, 1'b0, 0, nb(-3, 32767, 0, 32767), z));
    send_pixel(make_req(OP_FWD, 4'h3, 1'b0, 0, nb(-1, -1, -1, 0), z));
    // backward, same phases
    send_pixel(make_req(OP_BWD, 4'h0, 1'b0, 7, z, nb(1234, -32768, -32768, -32768)));
    send_pixel(make_req(OP_BWD, 4'h4, 1'b0, 0, z, nb(32767, 32767, -1, -1)));
    send_pixel(make_req(OP_BWD, 4'h8, 1'b0, 0, z, nb(-32768, 5, -32767, 5)));
    send_pixel(make_req(OP_BWD, 4'hC, 1'b0, 0, z, nb(-32768, -32768, -32768, -32768)));
    // phase bits of the unused reference have no effect
    send_pixel(make_req(OP_FWD, 4'hC, 1'b0, 3, nb(100, 0, 0, 0),
                        nb(32767, -32768, 32767, -32768)));
    send_pixel(make_req(OP_BWD, 4'h3, 1'b0, 3, nb(32767, -32768, 32767, -32768),
                        nb(-100, 0, 0, 0)));
    // average of both predictions
    send_pixel(make_req(OP_AVG, 4'h0, 1'b0, 0, nb(-1, 9, 9, 9), nb(0, 9, 9, 9)));
    send_pixel(make_req(OP_AVG, 4'hF, 1'b0, -5, nb(-7, 2, -3, 1), nb(11, -6, 4, 32767)));
    // saturation both ways, then saturation followed by chroma clamp
    send_pixel(make_req(OP_FWD, 4'h0, 1'b0, 32767, nb(32767, 0, 0, 0), z));
    send_pixel(make_req(OP_BWD, 4'h0, 1'b0, -32768, z, nb(-32768, 0, 0, 0)));
    send_pixel(make_req(OP_AVG, 4'h0, 1'b1, 32767, nb(32767, 0, 0, 0),
                        nb(32767, 0, 0, 0)));
    send_pixel(make_req(OP_AVG, 4'hF, 1'b1, -32768, nb(-32768, -32768, -32768, -32768),
                        nb(-32768, -32768, -32768, -32768)));
  endtask

  task automatic test_whole_pel_copy();
    set_half_pel(1'b0);
    send_pixel(make_req(OP_FWD, 4'hF, 1'b0, 1, nb(-3, 32767, 32767, 32767), nb(0, 0, 0, 0)));
    send_pixel(make_req(OP_BWD, 4'hF, 1'b0, 1, nb(0, 0, 0, 0), nb(-3, -32768, 5, 5)));
    send_pixel(make_req(OP_AVG, 4'hF, 1'b1, 0, nb(-1, 7, 7, 7), nb(0, -7, -7, -7)));
  endtask

  task automatic test_random_pixels(int unsigned count, logic en, bit with_idle);
    set_half_pel(en);
    idle_on = with_idle;
    repeat (count) send_pixel(random_pixel());
  endtask

  initial begin
    // driven at time zero so the asynchronous reset sees a falling edge
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_corners();
    test_whole_pel_copy();
    test_random_pixels(400, 1'b1, 1'b1);
    test_random_pixels(350, 1'b0, 1'b1);
    test_random_pixels(250, 1'b1, 1'b0);
    test_random_pixels(150, 1'b0, 1'b0);
    test_random_pixels(250, 1'b1, 1'b1);

    idle_on = 1'b1;
    wait_for_idle();
    $display("Covered: directed corners (copy, 2-tap, 4-tap, average, saturation, chroma clamp)");
    $display("and random pixels; %0d sent, %0d checked, %0d enable writes",
             sent_count, checked_count, cfg_writes);
    if (fail_count == 0) begin
      $display("PASS half_pel_motion_comp_reconstruct_top");
    end else begin
      $display("FAIL half_pel_motion_comp_reconstruct_top");
    end
    $finish;
  end

endmodule

### sim.f
hdl/mcr_pkg.sv
hdl/mcr_predict.sv
hdl/half_pel_motion_comp_reconstruct_top.sv
hdl/mcr_checker.sv
dv/tb_half_pel_motion_comp_reconstruct_top.sv
